FILE: hw/rtl/lvr_pkg.sv
package lvr_pkg;

	// Sizes
	localparam int MAX_PARTICLES = 64;
	localparam int IDX_W = $clog2(MAX_PARTICLES);
	localparam int CNT_W = IDX_W + 1;
	localparam int W_W = 16;
	localparam int ACC_W = W_W + IDX_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Configuration register indexes
	localparam cfg_idx_t CFG_PARTICLE_COUNT = 2'd0;
	localparam cfg_idx_t CFG_STRIDE = 2'd1;
	localparam cfg_idx_t CFG_START_OFFSET = 2'd2;

	// Reset values
	localparam logic [CNT_W-1:0] RST_PARTICLE_COUNT = CNT_W'(MAX_PARTICLES);
	localparam logic [W_W-1:0] RST_STRIDE = 16'd1024;
	localparam logic [W_W-1:0] RST_START_OFFSET = 16'd0;

	// Sequencer steps
	typedef enum logic [1:0] {
		STEP_LOAD,
		STEP_INIT,
		STEP_SUM,
		STEP_WALK
	} step_t;

	// Jump conditions
	typedef enum logic [1:0] {
		COND_STAY,
		COND_ALWAYS,
		COND_LAST_IN,
		COND_RUN_DONE
	} cond_t;

	typedef struct packed {
		logic take_in;
		logic init_walk;
		logic load_sum;
		logic walk;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	typedef struct packed {
		logic accept_last;
		logic run_done;
	} seq_stat_t;

	// Control store
	function automatic ctrl_word_t ucode_rom(input step_t step);
		ctrl_word_t w;
		w = '{take_in: 1'b0, init_walk: 1'b0, load_sum: 1'b0, walk: 1'b0,
			cond: COND_STAY, target: STEP_LOAD};
		case (step)
			STEP_LOAD: begin
				w.take_in = 1'b1;
				w.cond = COND_LAST_IN;
				w.target = STEP_INIT;
			end
			STEP_INIT: begin
				w.init_walk = 1'b1;
				w.cond = COND_ALWAYS;
				w.target = STEP_SUM;
			end
			STEP_SUM: begin
				w.load_sum = 1'b1;
				w.cond = COND_ALWAYS;
				w.target = STEP_WALK;
			end
			STEP_WALK: begin
				w.walk = 1'b1;
				w.cond = COND_RUN_DONE;
				w.target = STEP_LOAD;
			end
			default: begin
				w.cond = COND_ALWAYS;
				w.target = STEP_LOAD;
			end
		endcase
		return w;
	endfunction

endpackage

FILE: hw/rtl/lvr_seq.sv
module lvr_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  lvr_pkg::seq_stat_t  stat,
	output lvr_pkg::ctrl_word_t ctrl
);
	import lvr_pkg::*;

	step_t pc_q;
	step_t pc_next;
	logic  jump;

	// Fetch the control word and pick the next step
	always_comb begin
		ctrl = ucode_rom(pc_q);
		case (ctrl.cond)
			COND_STAY:     jump = 1'b0;
			COND_ALWAYS:   jump = 1'b1;
			COND_LAST_IN:  jump = stat.accept_last;
			COND_RUN_DONE: jump = stat.run_done;
			default:       jump = 1'b0;
		endcase
		pc_next = jump ? ctrl.target : pc_q;
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_LOAD;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

FILE: hw/rtl/low_variance_resampler.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_stall    weight, last_weight
// out       output     out_valid/out_stall  chosen_index, last_choice
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Weights are taken back to back in the load step; the store is written through one port.
// After the last weight, the walk passes the setup steps INIT and SUM, then in WALK takes
// one particle step, or emits one index while the result register is free, per cycle.
// The walk runs off one registered read port of the weight store.
// Reset is asynchronous; the weight store is not cleared.
// A stalled output holds back the next index until the result register frees up; particle steps go on.
module low_variance_resampler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [lvr_pkg::W_W-1:0]         weight,
	input  logic                            last_weight,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [lvr_pkg::IDX_W-1:0]       chosen_index,
	output logic                            last_choice,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  lvr_pkg::cfg_idx_t               cfg_index,
	input  logic [lvr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lvr_pkg::*;

	ctrl_word_t ctrl;
	seq_stat_t  stat;

	logic [CNT_W-1:0] particle_count_q;
	logic [W_W-1:0]   stride_q;
	logic [W_W-1:0]   start_offset_q;
	logic [CNT_W-1:0] load_count_q;

	logic [W_W-1:0]   wmem [MAX_PARTICLES];
	logic [W_W-1:0]   rd_q;
	logic [IDX_W-1:0] rd_addr;

	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [ACC_W-1:0] csum_q;
	logic [ACC_W-1:0] thr_q;

	logic             out_valid_q;
	logic [IDX_W-1:0] chosen_index_q;
	logic             last_choice_q;

	logic [CNT_W-1:0] cnt_m1;
	logic [IDX_W-1:0] n_m1;
	logic             in_xfer;
	logic             store_full;
	logic             out_free;
	logic             advance;
	logic             emit;
	logic             final_slot;

	lvr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// Clamp the particle count to 1..MAX_PARTICLES, kept as n-1
	always_comb begin
		cnt_m1 = particle_count_q - CNT_W'(1);
		if (particle_count_q == '0) begin
			n_m1 = '0;
		end else if (particle_count_q > CNT_W'(MAX_PARTICLES)) begin
			n_m1 = IDX_W'(MAX_PARTICLES - 1);
		end else begin
			n_m1 = cnt_m1[IDX_W-1:0];
		end
	end

	// Walk decisions
	assign in_stall   = !ctrl.take_in;
	assign in_xfer    = in_valid && !in_stall;
	assign store_full = (load_count_q >= CNT_W'(MAX_PARTICLES));
	assign out_free   = !out_valid_q || !out_stall;
	assign advance    = ctrl.walk && (thr_q > csum_q) && (i_q < n_m1);
	assign emit       = ctrl.walk && !advance && out_free;
	assign final_slot = (j_q == n_m1);
	assign rd_addr    = ctrl.init_walk ? '0 : (i_q + IDX_W'(1) + IDX_W'(advance));

	assign stat.accept_last = in_xfer && last_weight;
	assign stat.run_done    = emit && final_slot;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			particle_count_q <= RST_PARTICLE_COUNT;
			stride_q         <= RST_STRIDE;
			start_offset_q   <= RST_START_OFFSET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PARTICLE_COUNT: particle_count_q <= cfg_data[CNT_W-1:0];
				CFG_STRIDE:         stride_q <= cfg_data[W_W-1:0];
				CFG_START_OFFSET:   start_offset_q <= cfg_data[W_W-1:0];
				default: ;
			endcase
		end
	end

	// Load position: advance on each stored weight, rewind after the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
		end else if (stat.run_done) begin
			load_count_q <= '0;
		end else if (in_xfer && !store_full) begin
			load_count_q <= load_count_q + CNT_W'(1);
		end
	end

	// Weight store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (in_xfer && !store_full) begin
			wmem[load_count_q[IDX_W-1:0]] <= weight;
		end
		rd_q <= wmem[rd_addr];
	end

	// Walk registers
	always_ff @(posedge clk) begin
		if (ctrl.init_walk) begin
			i_q   <= '0;
			j_q   <= '0;
			thr_q <= ACC_W'(start_offset_q);
		end else begin
			if (advance) begin
				i_q <= i_q + IDX_W'(1);
			end
			if (emit) begin
				j_q   <= j_q + IDX_W'(1);
				thr_q <= thr_q + ACC_W'(stride_q);
			end
		end
		if (ctrl.load_sum) begin
			csum_q <= ACC_W'(rd_q);
		end else if (advance) begin
			csum_q <= csum_q + ACC_W'(rd_q);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			chosen_index_q <= i_q;
			last_choice_q  <= final_slot;
		end
	end

	assign out_valid    = out_valid_q;
	assign chosen_index = chosen_index_q;
	assign last_choice  = last_choice_q;

endmodule

FILE: hw/rtl/lvr_chk.sv
module lvr_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            last_weight,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [lvr_pkg::IDX_W-1:0]       chosen_index,
	input logic                            last_choice
);

	// A last weight starts the walk, so the input side closes next cycle
	a_last_closes_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_weight |=> in_stall)
		else $error("input still open after last weight transfer");

	// A pending non-final index means the walk is still running
	a_midrun_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_choice |-> in_stall)
		else $error("input open while the run is unfinished");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(chosen_index)
			&& $stable(last_choice))
		else $error("stalled result changed");

endmodule

bind low_variance_resampler lvr_chk u_lvr_chk (.*);

FILE: tb/sv/low_variance_resampler_test.sv
module low_variance_resampler_test;
	import lvr_pkg::*;

	localparam int RANDOM_ITEMS = 160;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 150;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DIR_ROWS = 35;
	localparam cfg_idx_t CFG_SPARE = 2'd3;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		cfg_idx_t idx;
		logic [W_W-1:0] data;
		logic last;
		logic pin;
		logic [IDX_W-1:0] pin_idx;
	} row_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic last;
	} pick_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [W_W-1:0] weight;
	logic last_weight;
	logic out_valid;
	logic out_stall;
	logic [IDX_W-1:0] chosen_index;
	logic last_choice;
	logic cfg_valid;
	logic cfg_ready;
	cfg_idx_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predictor state: weight store, load position and register copies
	logic [W_W-1:0] wt_mem [MAX_PARTICLES] = '{default: '0};
	int fill_pos = 0;
	logic [CNT_W-1:0] count_raw = RST_PARTICLE_COUNT;
	logic [W_W-1:0] stride_q = RST_STRIDE;
	logic [W_W-1:0] offset_q = RST_START_OFFSET;

	pick_t expected_picks [$];
	int mismatches = 0;
	int unsigned cycles = 0;
	logic pin_on = 1'b0;
	logic [IDX_W-1:0] pin_idx = '0;
	bit hold_req = 1'b0;
	int burst_left = 4;

	// Directed rows: weights are sent in order, registers written when idle.
	// A pinned last row expects every index of its run to equal pin_idx.
	row_t dir_plan [DIR_ROWS] = '{
		// single particle, then a count of zero treated as one
		'{ROW_CFG, CFG_PARTICLE_COUNT, 16'd1, 1'b0, 1'b0, 6'd0},
		'{ROW_CFG, CFG_STRIDE, 16'hFFFF, 1'b0, 1'b0, 6'd0},
		'{ROW_CFG, CFG_START_OFFSET, 16'h0000, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, '0, 16'hFFFF, 1'b1, 1'b1, 6'd0},
		'{ROW_CFG, CFG_PARTICLE_COUNT, 16'd0, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, '0, 16'h0000, 1'b1, 1'b1, 6'd0},
		// first particle holds all the weight
		'{ROW_CFG, CFG_PARTICLE_COUNT, 16'd2, 1'b0, 1'b0, 6'd0},
		'{ROW_CFG, CFG_STRIDE, 16'h8000, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, '0, 16'hFFFF, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, '0, 16'h0000, 1'b1, 1'b1, 6'd0},
		// all weights zero: the walk runs past the end and saturates
		'{ROW_CFG, CFG_PARTICLE_COUNT, 16'd4, 1'b0, 1'b0, 6'd0},
		'{ROW_CFG, CFG_STRIDE, 16'd1, 1'b0, 1'b0, 6'd0},
		'{ROW_CFG, CFG_START_OFFSET, 16'd1, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, '0, 16'h0000, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, '0, 16'h0000, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, '0, 16'h0000, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, '0, 16'h0000, 1'b1, 1'b1, 6'd3},
		// largest stride and offset, largest weights
		'{ROW_CFG, CFG_STRIDE, 16'hFFFF, 1'b0, 1'b0, 6'd0},
		'{ROW_CFG, CFG_START_OFFSET, 16'hFFFF, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, '0, 16'hFFFF, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, '0, 16'hFFFF, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, '0, 16'hFFFF, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, '0, 16'hFFFF, 1'b1, 1'b0, 6'd0},
		// unused index must leave the registers alone
		'{ROW_CFG, CFG_SPARE, 16'hA5A5, 1'b0, 1'b0, 6'd0},
		// more weights than particles in use
		'{ROW_CFG, CFG_PARTICLE_COUNT, 16'd3, 1'b0, 1'b0, 6'd0},
		'{ROW_CFG, CFG_STRIDE, 16'h5555, 1'b0, 1'b0, 6'd0},
		'{ROW_CFG, CFG_START_OFFSET, 16'h1234, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, '0, 16'h5555, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, '0, 16'hAAAA, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, '0, 16'h0001, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, '0, 16'h8000, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, '0, 16'h7FFF, 1'b1, 1'b0, 6'd0},
		// fewer weights than particles: old entries fill the rest
		'{ROW_CFG, CFG_PARTICLE_COUNT, 16'd4, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, '0, 16'h2AAA, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, '0, 16'hD555, 1'b1, 1'b0, 6'd0}
	};

	low_variance_resampler uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.weight(weight),
		.last_weight(last_weight),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.chosen_index(chosen_index),
		.last_choice(last_choice),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d indices pending", cycles,
				expected_picks.size());
			$display("FAIL low_variance_resampler");
			$finish;
		end
	end

	function automatic int unsigned eff_count(input logic [CNT_W-1:0] raw);
		if (raw == 0)
			return 1;
		if (raw > MAX_PARTICLES)
			return MAX_PARTICLES;
		return raw;
	endfunction

	// Store one weight; on the last one, walk the thresholds and queue the picks
	function automatic void absorb_weight(input logic [W_W-1:0] w, input logic last);
		int unsigned n, i, j, csum, thr;
		pick_t p;
		if (fill_pos < MAX_PARTICLES) begin
			wt_mem[fill_pos] = w;
			fill_pos++;
		end
		if (last) begin
			n = eff_count(count_raw);
			i = 0;
			csum = wt_mem[0];
			for (j = 0; j < n; j++) begin
				thr = offset_q + j * stride_q;
				while (thr > csum && i + 1 < n) begin
					i++;
					csum += wt_mem[i];
				end
				p.idx = pin_on ? pin_idx : IDX_W'(i);
				p.last = (j + 1 == n);
				expected_picks = {expected_picks, p};
			end
			fill_pos = 0;
		end
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("cycle %0d: mismatch: %s", cycles, what);
	endtask

	// Observe every transfer on the three channels
	always @(posedge clk) begin
		pick_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PARTICLE_COUNT: count_raw = cfg_data[CNT_W-1:0];
					CFG_STRIDE: stride_q = cfg_data;
					CFG_START_OFFSET: offset_q = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				absorb_weight(weight, last_weight);
			if (out_valid && !out_stall) begin
				if (expected_picks.size() == 0) begin
					flag_mismatch($sformatf("index %0d with nothing pending", chosen_index));
				end else begin
					want = expected_picks.pop_front();
					if (chosen_index !== want.idx)
						flag_mismatch($sformatf("chosen_index %0d, want %0d",
							chosen_index, want.idx));
					if (last_choice !== want.last)
						flag_mismatch($sformatf("last_choice %0b, want %0b",
							last_choice, want.last));
				end
			end
		end
	end

	// Output side: stall patterns in random segments, plus one long hold-off
	initial begin : receiver
		int unsigned mode, span, t;
		bit hold_done;
		hold_done = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				repeat (HOLD_CYCLES) @(negedge clk) out_stall <= 1'b1;
				hold_done = 1'b1;
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(5, 60);
			for (t = 0; t < span; t++) begin
				@(negedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= 1'($urandom_range(0, 1));
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= (t % 5 == 4);
				endcase
			end
		end
	end

	task automatic idle(input int unsigned n);
		repeat (n) @(negedge clk) begin
			in_valid <= 1'b0;
			weight <= W_W'($urandom);
		end
	endtask

	// Drop valid between bursts of random length
	task automatic pace();
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			idle(($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6));
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
		end
	endtask

	task automatic send_weight(input logic [W_W-1:0] w, input logic last, input logic pin,
			input logic [IDX_W-1:0] pidx);
		@(negedge clk);
		in_valid <= 1'b1;
		weight <= w;
		last_weight <= last;
		pin_on = pin;
		pin_idx = pidx;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// Hold the input idle until every pending index has arrived
	task automatic settle();
		@(negedge clk) in_valid <= 1'b0;
		while (expected_picks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned r, k, n, cap, w, run, run_len, filled, rand_items, i;
		bit after_item, well, sparse;
		row_t row;
		logic [CNT_W-1:0] plan_raw;
		logic [W_W-1:0] plan_stride, plan_offset;
		in_valid = 1'b0;
		weight = '0;
		last_weight = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PARTICLE_COUNT;
		cfg_data = '0;
		arst_n = 1'b0;
		plan_raw = RST_PARTICLE_COUNT;
		filled = 0;
		run_len = 0;
		rand_items = 0;
		after_item = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Walk the directed table
		for (r = 0; r < DIR_ROWS; r++) begin
			row = dir_plan[r];
			if (row.kind == ROW_CFG) begin
				if (after_item)
					settle();
				after_item = 1'b0;
				write_reg(row.idx, row.data);
				if (row.idx == CFG_PARTICLE_COUNT)
					plan_raw = row.data[CNT_W-1:0];
			end else begin
				after_item = 1'b1;
				send_weight(row.data, row.last, row.pin, row.pin_idx);
				run_len++;
				if (row.last) begin
					if (run_len > filled)
						filled = (run_len > MAX_PARTICLES) ? MAX_PARTICLES : run_len;
					run_len = 0;
				end
				pace();
			end
		end

		// Random runs: mostly well-formed weight sets, some broken ones
		run = 0;
		while (rand_items < RANDOM_ITEMS) begin
			if (run == 0 || (run > 3 && $urandom_range(0, 2) == 0)) begin
				settle();
				r = (run == 0) ? 0 : $urandom_range(0, 9);
				case (r)
					0: plan_raw = CNT_W'(MAX_PARTICLES);
					1: plan_raw = '0;
					2: plan_raw = CNT_W'(1);
					3: plan_raw = CNT_W'($urandom_range(MAX_PARTICLES + 1, 127));
					default: plan_raw = CNT_W'($urandom_range(2, 16));
				endcase
				n = eff_count(plan_raw);
				plan_stride = (n == 1) ? 16'hFFFF : W_W'(65536 / n);
				case ($urandom_range(0, 5))
					0: plan_stride = 16'd1;
					1: plan_stride = 16'hFFFF;
					2: plan_stride = plan_stride - 16'd8 + W_W'($urandom_range(0, 15));
					default: ;
				endcase
				if (plan_stride == 0)
					plan_stride = 16'd1;
				case ($urandom_range(0, 5))
					0: plan_offset = 16'hFFFF;
					1: plan_offset = 16'h0000;
					default: plan_offset = W_W'($urandom_range(0, plan_stride - 1));
				endcase
				write_reg(CFG_PARTICLE_COUNT, {($urandom_range(0, 3) == 0)
					? 9'($urandom) : 9'd0, plan_raw});
				write_reg(CFG_STRIDE, plan_stride);
				write_reg(CFG_START_OFFSET, plan_offset);
				if ($urandom_range(0, 7) == 0)
					write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
			end
			if (run == 0)
				hold_req = 1'b1;

			// Pick the run length; never let the walk reach an unwritten entry
			n = eff_count(plan_raw);
			well = (run == 0) || ($urandom_range(0, 9) < 7);
			if (well) begin
				k = n;
			end else begin
				k = ($urandom_range(0, 5) == 0) ? $urandom_range(65, 68)
					: $urandom_range(1, n + 4);
				if (k < n && n > filled)
					k = n;
			end
			cap = 131072 / n;
			if (cap > 65535)
				cap = 65535;
			sparse = ($urandom_range(0, 3) == 0);
			for (i = 1; i <= k; i++) begin
				if (well)
					w = $urandom_range(0, cap);
				else if (sparse && $urandom_range(0, 1) == 1)
					w = 0;
				else
					w = $urandom;
				send_weight(W_W'(w), i == k, 1'b0, '0);
				rand_items++;
				pace();
			end
			if (k > filled)
				filled = (k > MAX_PARTICLES) ? MAX_PARTICLES : k;
			run++;
		end

		// Drain and wait out the walk
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_picks.size() == 0)
			$display("PASS low_variance_resampler");
		else
			$display("FAIL low_variance_resampler");
		$finish;
	end

endmodule
